FILE: design/wbss_pkg.sv
`default_nettype none

package wbss_pkg;

    localparam int PATTERN_MAX = 24;
    localparam int INDEX_BITS  = 32;
    localparam int BYTE_W      = 8;
    localparam int WIN_W       = PATTERN_MAX * BYTE_W;
    localparam int LEN_W       = 5;
    localparam int POS_W       = 32;
    localparam int DELTA_W     = LEN_W + 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int PAT_ALL_W   = 3 * CFG_DATA_W;
    localparam int WILD_W      = 24;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_FIRST  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_SECOND = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_THIRD  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WILD_MASK  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_OFF   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_END = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS   = 4'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_beat;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             not_found_error;
    } t_out_beat;

    typedef struct packed {
        logic [WIN_W-1:0]       pattern;
        logic [PATTERN_MAX-1:0] care;
        logic [LEN_W-1:0]       length;
        logic                   len_ok;
        logic [DELTA_W-1:0]     delta;
        logic                   search_last;
        logic                   suppress_error;
    } t_cmp_cfg;

endpackage

`default_nettype wire

FILE: design/wbss_cfg.sv
`default_nettype none

module wbss_cfg (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [wbss_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [wbss_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output wbss_pkg::t_cmp_cfg                        o_cmp
);

    logic [wbss_pkg::CFG_DATA_W-1:0] r_pat_first;
    logic [wbss_pkg::CFG_DATA_W-1:0] r_pat_second;
    logic [wbss_pkg::CFG_DATA_W-1:0] r_pat_third;
    logic [wbss_pkg::WILD_W-1:0]     r_wild;
    logic [wbss_pkg::LEN_W-1:0]      r_len;
    logic [wbss_pkg::LEN_W-1:0]      r_off;
    logic                            r_search_last;
    logic                            r_suppress;

    wbss_pkg::t_cmp_cfg r_cmp;
    wbss_pkg::t_cmp_cfg n_cmp;

    logic [wbss_pkg::PAT_ALL_W-1:0]   w_pat_all;
    logic [wbss_pkg::LEN_W:0]         w_shift;
    logic [wbss_pkg::PATTERN_MAX-1:0] w_len_mask;
    logic [wbss_pkg::PATTERN_MAX-1:0] w_care_raw;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_first   <= '0;
            r_pat_second  <= '0;
            r_pat_third   <= '0;
            r_wild        <= '0;
            r_len         <= '0;
            r_off         <= '0;
            r_search_last <= 1'b0;
            r_suppress    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wbss_pkg::REG_PAT_FIRST:  r_pat_first   <= i_cfg_data;
                wbss_pkg::REG_PAT_SECOND: r_pat_second  <= i_cfg_data;
                wbss_pkg::REG_PAT_THIRD:  r_pat_third   <= i_cfg_data;
                wbss_pkg::REG_WILD_MASK:  r_wild        <= i_cfg_data[wbss_pkg::WILD_W-1:0];
                wbss_pkg::REG_PAT_LEN:    r_len         <= i_cfg_data[wbss_pkg::LEN_W-1:0];
                wbss_pkg::REG_MARK_OFF:   r_off         <= i_cfg_data[wbss_pkg::LEN_W-1:0];
                wbss_pkg::REG_SEARCH_END: r_search_last <= i_cfg_data[0];
                wbss_pkg::REG_SUPPRESS:   r_suppress    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The signature is aligned once to the newest end of the window, so the
    // scan compares byte for byte at fixed places.
    always_comb begin
        w_pat_all = {r_pat_third, r_pat_second, r_pat_first};
        w_shift   = (wbss_pkg::LEN_W + 1)'(wbss_pkg::PATTERN_MAX) - {1'b0, r_len};
        for (int j = 0; j < wbss_pkg::PATTERN_MAX; j++) begin
            w_len_mask[j] = (wbss_pkg::LEN_W)'(j) < r_len;
        end
        w_care_raw = w_len_mask & ~r_wild[wbss_pkg::PATTERN_MAX-1:0];

        n_cmp.pattern        = w_pat_all[wbss_pkg::WIN_W-1:0] << {w_shift, 3'b000};
        n_cmp.care           = w_care_raw << w_shift;
        n_cmp.length         = r_len;
        n_cmp.len_ok         = (r_len != '0) &&
                               ({1'b0, r_len} <= (wbss_pkg::LEN_W + 1)'(wbss_pkg::PATTERN_MAX));
        n_cmp.delta          = (wbss_pkg::DELTA_W)'(r_off) + (wbss_pkg::DELTA_W)'(1)
                               - (wbss_pkg::DELTA_W)'(r_len);
        n_cmp.search_last    = r_search_last;
        n_cmp.suppress_error = r_suppress;
    end

    always_ff @(posedge i_clk) begin
        r_cmp <= n_cmp;
    end

    assign o_cmp = r_cmp;

endmodule

`default_nettype wire

FILE: design/wbss_scan.sv
`default_nettype none

module wbss_scan (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire wbss_pkg::t_in_beat  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output wbss_pkg::t_out_beat      o_out,
    input  wire wbss_pkg::t_cmp_cfg  i_cmp
);

    logic                r_in_valid;
    wbss_pkg::t_in_beat  r_in;

    logic [wbss_pkg::WIN_W-1:0]      r_window;
    logic [wbss_pkg::LEN_W-1:0]      r_fill;
    logic [wbss_pkg::INDEX_BITS-1:0] r_count;
    logic                            r_have;
    logic [wbss_pkg::INDEX_BITS-1:0] r_best;

    logic                r_out_valid;
    wbss_pkg::t_out_beat r_out;

    logic                             w_new_result;
    logic                             w_advance;
    logic [wbss_pkg::WIN_W-1:0]       w_win;
    logic [wbss_pkg::LEN_W-1:0]       w_fill;
    logic [wbss_pkg::PATTERN_MAX-1:0] w_byte_ok;
    logic                             w_match;
    logic [wbss_pkg::INDEX_BITS-1:0]  w_pos;
    logic                             w_have;
    logic [wbss_pkg::INDEX_BITS-1:0]  w_best;

    // Only a last byte needs the result register, so a waiting result holds the
    // input back only when such a byte is about to overwrite it.
    assign w_new_result = r_in_valid && r_in.last_byte;
    assign w_advance    = !(w_new_result && r_out_valid && i_out_stall);
    assign o_in_stall   = !w_advance;

    always_comb begin
        w_win  = {r_in.data_byte, r_window[wbss_pkg::WIN_W-1:wbss_pkg::BYTE_W]};
        w_fill = (r_fill == (wbss_pkg::LEN_W)'(wbss_pkg::PATTERN_MAX)) ?
                 r_fill : r_fill + (wbss_pkg::LEN_W)'(1);
        for (int j = 0; j < wbss_pkg::PATTERN_MAX; j++) begin
            w_byte_ok[j] = !i_cmp.care[j] ||
                (w_win[j*wbss_pkg::BYTE_W +: wbss_pkg::BYTE_W] ==
                 i_cmp.pattern[j*wbss_pkg::BYTE_W +: wbss_pkg::BYTE_W]);
        end
        w_match = i_cmp.len_ok && (w_fill >= i_cmp.length) && (&w_byte_ok);
        // Start of the match plus the marked offset, taken from the old count.
        w_pos   = r_count + {{(wbss_pkg::INDEX_BITS - wbss_pkg::DELTA_W)
                              {i_cmp.delta[wbss_pkg::DELTA_W-1]}}, i_cmp.delta};
        w_have  = r_have || w_match;
        w_best  = (w_match && (i_cmp.search_last || !r_have)) ? w_pos : r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_fill      <= '0;
            r_count     <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_in_valid <= i_in_valid;
                if (r_in_valid) begin
                    if (r_in.last_byte) begin
                        r_fill  <= '0;
                        r_count <= '0;
                        r_have  <= 1'b0;
                    end else begin
                        r_fill  <= w_fill;
                        r_count <= r_count + (wbss_pkg::INDEX_BITS)'(1);
                        r_have  <= w_have;
                    end
                end
            end
            if (w_advance && w_new_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_in <= i_in;
            if (r_in_valid) begin
                r_window <= w_win;
                r_best   <= w_best;
            end
            if (w_new_result) begin
                r_out.found           <= w_have;
                r_out.match_position  <= w_have ? (wbss_pkg::POS_W)'(w_best) : '0;
                r_out.not_found_error <= !w_have && !i_cmp.suppress_error;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

FILE: design/wildcard_byte_signature_scan_top.sv
`default_nettype none

// Channel   Direction  Handshake                  Beat
// input     in         i_in_valid / o_in_stall     one region byte, last-byte flag
// output    out        o_out_valid / i_out_stall   found, match position, error flag
// config    in         i_cfg_valid / o_cfg_ready   register index and 64-bit data
//
// One byte is accepted in every cycle in which the input is not stalled; a result is
// registered in the result register after its last byte has passed the input register.
// The window compare and the match update sit between the input and result registers.
// Reset is synchronous and clears the scan state and the configuration registers to zero.
// A held result stalls the input only while a further last byte waits for the result
// register; no beat is lost or repeated.

module wildcard_byte_signature_scan_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire wbss_pkg::t_in_beat               i_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output wbss_pkg::t_out_beat                   o_out,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [wbss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [wbss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    wbss_pkg::t_cmp_cfg w_cmp;

    wbss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmp       (w_cmp)
    );

    wbss_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cmp       (w_cmp)
    );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 1900;
    localparam logic [wbss_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_REG = 4'd8;
    localparam logic [wbss_pkg::CFG_IDX_W-1:0] LAST_UNUSED_REG  = 4'd15;

    class signature_scoreboard;
        logic [wbss_pkg::CFG_DATA_W-1:0] sig_word [3];
        logic [wbss_pkg::WILD_W-1:0]     wild_mask;
        logic [wbss_pkg::LEN_W-1:0]      sig_len;
        logic [wbss_pkg::LEN_W-1:0]      mark_off;
        logic                            search_last;
        logic                            suppress_err;
        logic [wbss_pkg::BYTE_W-1:0]     window [wbss_pkg::PATTERN_MAX];
        int                              window_fill;
        logic [wbss_pkg::POS_W-1:0]      bytes_seen;
        logic [wbss_pkg::POS_W-1:0]      best_start;
        logic                            have_match;
        wbss_pkg::t_out_beat             pending_reports [$];
        int unsigned                     errors;
        int unsigned                     bytes_total;
        int unsigned                     reports_seen;
        int unsigned                     matches_seen;

        function new();
            foreach (sig_word[i]) sig_word[i] = '0;
            wild_mask = '0;
            sig_len = '0;
            mark_off = '0;
            search_last = 1'b0;
            suppress_err = 1'b0;
            errors = 0;
            bytes_total = 0;
            reports_seen = 0;
            matches_seen = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (window[i]) window[i] = '0;
            window_fill = 0;
            bytes_seen = '0;
            best_start = '0;
            have_match = 1'b0;
        endfunction

        function logic [wbss_pkg::BYTE_W-1:0] sig_byte(int i);
            return sig_word[i / 8][(i % 8) * 8 +: 8];
        endfunction

        function void write_reg(logic [wbss_pkg::CFG_IDX_W-1:0] index,
                                logic [wbss_pkg::CFG_DATA_W-1:0] value);
            case (index)
                wbss_pkg::REG_PAT_FIRST:  sig_word[0] = value;
                wbss_pkg::REG_PAT_SECOND: sig_word[1] = value;
                wbss_pkg::REG_PAT_THIRD:  sig_word[2] = value;
                wbss_pkg::REG_WILD_MASK:  wild_mask = value[wbss_pkg::WILD_W-1:0];
                wbss_pkg::REG_PAT_LEN:    sig_len = value[wbss_pkg::LEN_W-1:0];
                wbss_pkg::REG_MARK_OFF:   mark_off = value[wbss_pkg::LEN_W-1:0];
                wbss_pkg::REG_SEARCH_END: search_last = value[0];
                wbss_pkg::REG_SUPPRESS:   suppress_err = value[0];
                default: ;
            endcase
        endfunction

        function bit window_hit();
            int len;
            int i;
            len = int'(sig_len);
            if (len == 0 || len > wbss_pkg::PATTERN_MAX || window_fill < len) return 1'b0;
            for (i = 0; i < len; i++) begin
                if (!wild_mask[i] &&
                    window[wbss_pkg::PATTERN_MAX - len + i] !== sig_byte(i)) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_byte(wbss_pkg::t_in_beat beat);
            wbss_pkg::t_out_beat report;
            int i;
            for (i = 0; i < wbss_pkg::PATTERN_MAX - 1; i++) window[i] = window[i + 1];
            window[wbss_pkg::PATTERN_MAX - 1] = beat.data_byte;
            if (window_fill < wbss_pkg::PATTERN_MAX) window_fill++;
            bytes_seen = bytes_seen + (wbss_pkg::POS_W)'(1);
            bytes_total++;
            if (window_hit() && (search_last || !have_match)) begin
                best_start = bytes_seen - (wbss_pkg::POS_W)'(sig_len);
                have_match = 1'b1;
            end
            if (beat.last_byte) begin
                report.found = have_match;
                report.match_position =
                    have_match ? best_start + (wbss_pkg::POS_W)'(mark_off) : '0;
                report.not_found_error = !have_match && !suppress_err;
                pending_reports.push_back(report);
                clear_scan();
            end
        endfunction

        function void check_report(wbss_pkg::t_out_beat got);
            wbss_pkg::t_out_beat want;
            if (pending_reports.size() == 0) begin
                $error("Result beat with no region outstanding: found=%0b position=%0d error=%0b",
                       got.found, got.match_position, got.not_found_error);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            reports_seen++;
            if (want.found) matches_seen++;
            if (got.found !== want.found) begin
                $error("found: expected %0b, got %0b", want.found, got.found);
                errors++;
            end
            if (got.match_position !== want.match_position) begin
                $error("match_position: expected %0d, got %0d",
                       want.match_position, got.match_position);
                errors++;
            end
            if (got.not_found_error !== want.not_found_error) begin
                $error("not_found_error: expected %0b, got %0b",
                       want.not_found_error, got.not_found_error);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    wbss_pkg::t_in_beat              i_in = '0;
    logic                            i_out_stall = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [wbss_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [wbss_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    wbss_pkg::t_out_beat             o_out;
    logic                            o_cfg_ready;

    signature_scoreboard          scan = new();
    logic [wbss_pkg::BYTE_W-1:0]  region_buf [$];
    int                           in_gap_pct = 0;
    int                           stall_pct = 0;
    int                           phases = 0;
    int unsigned                  cycles = 0;

    wildcard_byte_signature_scan_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) scan.check_report(o_out);
            if (i_in_valid && !o_in_stall) scan.take_byte(i_in);
            if (i_cfg_valid && o_cfg_ready) scan.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $error("Run stopped after %0d cycles with %0d results outstanding",
                   cycles, scan.pending_reports.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(16)) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [wbss_pkg::BYTE_W-1:0] value, input logic last);
        if (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(17, 1)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{data_byte: value, last_byte: last};
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_region();
        foreach (region_buf[i]) send_byte(region_buf[i], i == region_buf.size() - 1);
    endtask

    task automatic cfg_write(input logic [wbss_pkg::CFG_IDX_W-1:0] index,
                             input logic [wbss_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (scan.pending_reports.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    function automatic logic [wbss_pkg::CFG_DATA_W-1:0] junk_above(
            int width, logic [wbss_pkg::CFG_DATA_W-1:0] field);
        logic [wbss_pkg::CFG_DATA_W-1:0] junk;
        junk = $urandom_range(1) ? {$urandom, $urandom} : '0;
        return (junk << width) | field;
    endfunction

    task automatic random_config();
        logic [wbss_pkg::LEN_W-1:0]  len;
        logic [wbss_pkg::WILD_W-1:0] mask;
        logic [wbss_pkg::LEN_W-1:0]  off;
        case ($urandom_range(9))
            0: len = '0;
            1: len = (wbss_pkg::LEN_W)'(1);
            2: len = (wbss_pkg::LEN_W)'(wbss_pkg::PATTERN_MAX);
            3: len = (wbss_pkg::LEN_W)'($urandom_range(31, wbss_pkg::PATTERN_MAX + 1));
            4, 5, 6, 7: len = (wbss_pkg::LEN_W)'($urandom_range(8, 2));
            default: len = (wbss_pkg::LEN_W)'($urandom_range(wbss_pkg::PATTERN_MAX - 1, 9));
        endcase
        case ($urandom_range(3))
            0: mask = '0;
            1: mask = '1;
            default: mask = (wbss_pkg::WILD_W)'($urandom & $urandom);
        endcase
        case ($urandom_range(3))
            0: off = '0;
            1: off = (wbss_pkg::LEN_W)'(wbss_pkg::PATTERN_MAX - 1);
            2: off = '1;
            default: off = (wbss_pkg::LEN_W)'($urandom_range(31));
        endcase
        cfg_write(wbss_pkg::REG_PAT_FIRST, {$urandom, $urandom});
        cfg_write(wbss_pkg::REG_PAT_SECOND, {$urandom, $urandom});
        cfg_write(wbss_pkg::REG_PAT_THIRD, {$urandom, $urandom});
        cfg_write(wbss_pkg::REG_WILD_MASK,
                  junk_above(wbss_pkg::WILD_W, (wbss_pkg::CFG_DATA_W)'(mask)));
        cfg_write(wbss_pkg::REG_PAT_LEN,
                  junk_above(wbss_pkg::LEN_W, (wbss_pkg::CFG_DATA_W)'(len)));
        cfg_write(wbss_pkg::REG_MARK_OFF,
                  junk_above(wbss_pkg::LEN_W, (wbss_pkg::CFG_DATA_W)'(off)));
        cfg_write(wbss_pkg::REG_SEARCH_END,
                  junk_above(1, (wbss_pkg::CFG_DATA_W)'($urandom_range(1))));
        cfg_write(wbss_pkg::REG_SUPPRESS,
                  junk_above(1, (wbss_pkg::CFG_DATA_W)'($urandom_range(1))));
        if ($urandom_range(3) == 0) begin
            cfg_write((wbss_pkg::CFG_IDX_W)'($urandom_range(LAST_UNUSED_REG, FIRST_UNUSED_REG)),
                      {$urandom, $urandom});
        end
        i_cfg_valid <= 1'b0;
        phases++;
    endtask

    function automatic void make_region();
        int n;
        int len;
        int at;
        int flip;
        int i;
        bit narrow;
        logic [wbss_pkg::BYTE_W-1:0] value;
        region_buf.delete();
        case ($urandom_range(19))
            0: n = $urandom_range(3, 1);
            1, 2, 3: n = $urandom_range(120, 41);
            default: n = $urandom_range(40, 4);
        endcase
        narrow = $urandom_range(3) == 0;
        for (i = 0; i < n; i++) begin
            case (narrow ? $urandom_range(2) : 3)
                0: value = 8'h00;
                1: value = 8'hFF;
                2: value = scan.sig_byte(0);
                default: value = (wbss_pkg::BYTE_W)'($urandom);
            endcase
            region_buf.push_back(value);
        end
        len = int'(scan.sig_len);
        if (len >= 1 && len <= wbss_pkg::PATTERN_MAX && len <= n && $urandom_range(9) >= 2) begin
            repeat ($urandom_range(3, 1)) begin
                at = $urandom_range(n - len);
                for (i = 0; i < len; i++) begin
                    if (!scan.wild_mask[i]) region_buf[at + i] = scan.sig_byte(i);
                end
                if ($urandom_range(4) == 0) begin
                    flip = $urandom_range(len - 1);
                    region_buf[at + flip] ^= (wbss_pkg::BYTE_W)'($urandom_range(255, 1));
                end
            end
        end
    endfunction

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All registers still at reset, so the signature is empty and cannot match.
        region_buf = '{8'h00, 8'hFF};
        send_region();
        drain();

        cfg_write(wbss_pkg::REG_PAT_FIRST, 64'h0000_0000_005A_FF00);
        cfg_write(wbss_pkg::REG_PAT_SECOND, '1);
        cfg_write(wbss_pkg::REG_PAT_THIRD, 64'h8000_0000_0000_0001);
        cfg_write(wbss_pkg::REG_WILD_MASK, 64'h2);
        cfg_write(wbss_pkg::REG_PAT_LEN, 64'd3);
        cfg_write(wbss_pkg::REG_MARK_OFF, 64'd31);
        cfg_write(wbss_pkg::REG_SEARCH_END, 64'd0);
        cfg_write(wbss_pkg::REG_SUPPRESS, 64'd0);
        cfg_write(LAST_UNUSED_REG, '1);
        i_cfg_valid <= 1'b0;
        region_buf = '{8'h00, 8'h11, 8'h5A, 8'h00, 8'hFF, 8'h5A};
        send_region();
        drain();

        cfg_write(wbss_pkg::REG_SEARCH_END, 64'd1);
        i_cfg_valid <= 1'b0;
        send_region();
        drain();

        cfg_write(wbss_pkg::REG_SUPPRESS, 64'd1);
        i_cfg_valid <= 1'b0;
        region_buf = '{8'h00, 8'hFF};
        send_region();
        drain();

        cfg_write(wbss_pkg::REG_PAT_LEN, 64'd25);
        cfg_write(wbss_pkg::REG_SUPPRESS, 64'd0);
        i_cfg_valid <= 1'b0;
        region_buf = '{8'h00, 8'hFF, 8'h5A};
        send_region();

        while (scan.bytes_total < BYTE_TARGET) begin
            drain();
            random_config();
            if (scan.bytes_total > BYTE_TARGET - 250) begin
                in_gap_pct = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(3))
                    0: in_gap_pct = 0;
                    1: in_gap_pct = 5;
                    2: in_gap_pct = 20;
                    default: in_gap_pct = 50;
                endcase
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 5;
                    2: stall_pct = 20;
                    default: stall_pct = 50;
                endcase
            end
            repeat ($urandom_range(12, 4)) begin
                make_region();
                send_region();
                if ($urandom_range(15) == 0) drain();
            end
        end
        drain();
        repeat (10) @(negedge i_clk);

        $display("Scanned %0d bytes in %0d regions under %0d random register settings;",
                 scan.bytes_total, scan.reports_seen, phases);
        $display("%0d regions reported a match, with random stalls on both channels.",
                 scan.matches_seen);
        if (scan.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
